[rtl/deq_pkg.sv]
// ----------------------------------------------------------------------------
// deq_pkg
// Operation and status codes shared by the double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

	typedef enum logic [1:0] {
		OP_PUSH_FRONT = 2'd0,
		OP_POP_FRONT  = 2'd1,
		OP_PUSH_BACK  = 2'd2,
		OP_POP_BACK   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	localparam int unsigned VALUE_W = 32;

endpackage

[rtl/double_ended_queue.sv]
// ----------------------------------------------------------------------------
// double_ended_queue
// Bounded deque of signed 32-bit values kept in a ring buffer memory.
// ----------------------------------------------------------------------------
// Each request beat (s_tuser = operation, s_tdata = value) yields one result
// beat carrying the popped value (zero for pushes and errors), a status in
// m_tuser (ok, empty, full) and the occupancy after the operation. Pushes and
// rejected requests can stream back to back; a successful pop reads the
// ring memory through its registered read port, and no new request is taken
// while that read is pending, so the popped value reaches the output
// register first. A popped entry is always one an earlier push wrote, so
// the memory needs no clearing after reset. A request is taken only while
// the output register is empty or drains in the same cycle, so a result
// stalled on m_tready holds off the input.
// ----------------------------------------------------------------------------
module double_ended_queue
	import deq_pkg::*;
#(
	parameter int unsigned DEPTH = 16
) (
	input  logic clk,
	input  logic arst_n,

	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [VALUE_W-1:0]               s_tdata,   // [31:0] value_in
	input  logic [1:0]                       s_tuser,   // [1:0] func

	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [((VALUE_W + $clog2(DEPTH + 1) + 7) / 8) * 8 - 1:0] m_tdata,
	                                        // [31:0] value_out, then occupancy, zero pad
	output logic [1:0]                       m_tuser    // [1:0] status
);

	localparam int unsigned IDX_W = $clog2(DEPTH);
	localparam int unsigned CNT_W = $clog2(DEPTH + 1);
	localparam int unsigned SUM_W = IDX_W + 1;
	localparam int unsigned OUT_W = ((VALUE_W + CNT_W + 7) / 8) * 8;

	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [SUM_W-1:0] DEPTH_S  = SUM_W'(DEPTH);

	// ring storage
	logic [VALUE_W-1:0] mem [DEPTH];

	logic [IDX_W-1:0]   front_q;
	logic [CNT_W-1:0]   cnt_q;

	// pending pop waiting on memory read data
	logic               pend_s1;
	logic [VALUE_W-1:0] rdata_s1;
	logic [CNT_W-1:0]   occ_s1;

	// output register
	logic               out_valid_q;
	logic [VALUE_W-1:0] out_value_q;
	logic [CNT_W-1:0]   out_occ_q;
	status_t            out_st_q;

	op_t                op;
	logic               s_acc;
	logic               full;
	logic               empty;
	logic [IDX_W-1:0]   front_inc;
	logic [IDX_W-1:0]   front_dec;
	logic [SUM_W-1:0]   push_sum;
	logic [SUM_W-1:0]   pop_sum;
	logic [IDX_W-1:0]   back_push;
	logic [IDX_W-1:0]   back_pop;

	logic [IDX_W-1:0]   front_d;
	logic [CNT_W-1:0]   cnt_d;
	logic [IDX_W-1:0]   mem_idx;
	logic               do_wr;
	logic               do_rd;
	status_t            st_d;
	logic               wr_en;
	logic               rd_go;

	assign op     = op_t'(s_tuser);
	assign s_tready = !pend_s1 && (!out_valid_q || m_tready);
	assign s_acc  = s_tvalid && s_tready;
	assign full   = (cnt_q == CNT_FULL);
	assign empty  = (cnt_q == '0);

	assign front_inc = (front_q == IDX_LAST) ? '0 : front_q + IDX_W'(1);
	assign front_dec = (front_q == '0) ? IDX_LAST : front_q - IDX_W'(1);

	// front + count (push back) and front + count - 1 (pop back), mod DEPTH
	assign push_sum  = SUM_W'(front_q) + SUM_W'(cnt_q);
	assign pop_sum   = push_sum - SUM_W'(1);
	assign back_push = (push_sum >= DEPTH_S) ? IDX_W'(push_sum - DEPTH_S)
	                                         : IDX_W'(push_sum);
	assign back_pop  = (pop_sum >= DEPTH_S) ? IDX_W'(pop_sum - DEPTH_S)
	                                        : IDX_W'(pop_sum);

	always_comb begin
		front_d = front_q;
		cnt_d   = cnt_q;
		mem_idx = front_q;
		do_wr   = 1'b0;
		do_rd   = 1'b0;
		st_d    = ST_OK;
		unique case (op)
			OP_PUSH_FRONT: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					front_d = front_dec;
					mem_idx = front_dec;
					do_wr   = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			OP_POP_FRONT: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					front_d = front_inc;
					mem_idx = front_q;
					do_rd   = 1'b1;
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			OP_PUSH_BACK: begin
				if (full) begin
					st_d = ST_FULL;
				end else begin
					mem_idx = back_push;
					do_wr   = 1'b1;
					cnt_d   = cnt_q + CNT_W'(1);
				end
			end
			OP_POP_BACK: begin
				if (empty) begin
					st_d = ST_EMPTY;
				end else begin
					mem_idx = back_pop;
					do_rd   = 1'b1;
					cnt_d   = cnt_q - CNT_W'(1);
				end
			end
			default: begin
				st_d = ST_OK;
			end
		endcase
	end

	assign wr_en = s_acc && do_wr;
	assign rd_go = s_acc && do_rd;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[mem_idx] <= s_tdata;
		end
		if (rd_go) begin
			rdata_s1 <= mem[mem_idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			cnt_q   <= '0;
			pend_s1 <= 1'b0;
		end else begin
			pend_s1 <= rd_go;
			if (s_acc) begin
				front_q <= front_d;
				cnt_q   <= cnt_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rd_go) begin
			occ_s1 <= cnt_d;
		end
	end

	// a pending pop always finds the output register empty
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pend_s1 || (s_acc && !do_rd)) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pend_s1) begin
			out_value_q <= rdata_s1;
			out_occ_q   <= occ_s1;
			out_st_q    <= ST_OK;
		end else if (s_acc && !do_rd) begin
			out_value_q <= '0;
			out_occ_q   <= cnt_d;
			out_st_q    <= st_d;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_st_q;
	assign m_tdata  = OUT_W'({out_occ_q, out_value_q});

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_FULL)
		else $error("occupancy exceeds depth");

	a_front_bound: assert property (@(posedge clk) disable iff (!arst_n)
		front_q <= IDX_LAST)
		else $error("front index out of range");

	a_pend_out: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |=> out_valid_q)
		else $error("pop result not delivered after read");

	a_pend_free: assert property (@(posedge clk) disable iff (!arst_n)
		pend_s1 |-> !out_valid_q)
		else $error("pop read completes into occupied output register");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(s_acc && empty && (op == OP_POP_FRONT || op == OP_POP_BACK))
		|=> (!pend_s1 && out_valid_q && cnt_q == '0))
		else $error("pop on empty deque touched state");

endmodule

[tb/sv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the bounded double-ended queue.
// ----------------------------------------------------------------------------
// A short table of directed requests runs first: pops on empty, pushes of the
// extreme values, a wrap of the front pointer, a fill to capacity and pushes
// rejected as full. About 400 random requests follow, in bursts that lean
// toward filling, draining or neither, so that the queue sweeps between empty
// and full. A behavioral copy of the deque predicts every result beat, and
// result beats are matched in order against them or a directed row's own
// expected result. Both sides idle at random, with stretches of no idling.
// ----------------------------------------------------------------------------
module testbench;
	import deq_pkg::*;

	localparam int unsigned DEPTH   = 16;
	localparam int unsigned OCC_W   = $clog2(DEPTH + 1);
	localparam int unsigned M_W     = ((VALUE_W + OCC_W + 7) / 8) * 8;
	localparam int          DIR_N   = 25;
	localparam int          RAND_N  = 400;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic [OCC_W-1:0]   occupancy;
	} deque_result_t;

	typedef struct packed {
		op_t                op;
		logic [VALUE_W-1:0] value;
		logic               typed;   // want holds a hand-written result
		deque_result_t      want;
	} stim_row_t;

	logic clk;
	logic arst_n = 1'b0;

	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [VALUE_W-1:0] s_tdata  = '0;    // [31:0] value_in
	logic [1:0]         s_tuser  = '0;    // [1:0] func
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [M_W-1:0]     m_tdata;          // [31:0] value_out, [36:32] occupancy, pad
	logic [1:0]         m_tuser;          // [1:0] status

	// predicted deque contents
	logic [VALUE_W-1:0] deque_slots [DEPTH];
	int unsigned        front_slot = 0;
	int unsigned        held_count = 0;

	deque_result_t pending_results [$];
	int            error_count = 0;

	stim_row_t directed_rows [DIR_N] = '{
		'{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0}},
		'{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0}},
		'{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b1, '{32'h0000_0000, ST_OK,    5'd1}},
		// front pointer wraps below slot zero
		'{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_OK,    5'd2}},
		'{OP_POP_BACK,   32'h0000_0000, 1'b1, '{32'h7FFF_FFFF, ST_OK,    5'd1}},
		'{OP_POP_FRONT,  32'h0000_0000, 1'b1, '{32'h8000_0000, ST_OK,    5'd0}},
		'{OP_POP_FRONT,  32'hFFFF_FFFF, 1'b1, '{32'h0000_0000, ST_EMPTY, 5'd0}},
		// fill to capacity from both ends
		'{OP_PUSH_FRONT, 32'h0000_0000, 1'b0, '0},
		'{OP_PUSH_BACK,  32'hFFFF_FFFF, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'h5555_5555, 1'b0, '0},
		'{OP_PUSH_BACK,  32'hAAAA_AAAA, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'h0000_0001, 1'b0, '0},
		'{OP_PUSH_BACK,  32'h8000_0001, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'h7FFF_FFFE, 1'b0, '0},
		'{OP_PUSH_BACK,  32'h1234_5678, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'hDEAD_BEEF, 1'b0, '0},
		'{OP_PUSH_BACK,  32'h0F0F_0F0F, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'hF0F0_F0F0, 1'b0, '0},
		'{OP_PUSH_BACK,  32'h3333_3333, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'hCCCC_CCCC, 1'b0, '0},
		'{OP_PUSH_BACK,  32'h0000_FFFF, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'hFFFF_0000, 1'b0, '0},
		'{OP_PUSH_BACK,  32'h7FFF_FFFF, 1'b0, '0},
		'{OP_PUSH_FRONT, 32'h8000_0000, 1'b1, '{32'h0000_0000, ST_FULL,  5'd16}},
		'{OP_PUSH_BACK,  32'h0000_0001, 1'b1, '{32'h0000_0000, ST_FULL,  5'd16}}
	};

	double_ended_queue #(
		.DEPTH(DEPTH)
	) dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Regression FAIL");
		$finish;
	end

	// Applies one request to the predicted deque and returns its result.
	function automatic deque_result_t apply_deque_op(op_t op, logic [VALUE_W-1:0] value);
		deque_result_t res;
		int unsigned   slot;
		res.value  = '0;
		res.status = ST_OK;
		case (op)
			OP_PUSH_FRONT, OP_PUSH_BACK: begin
				if (held_count >= DEPTH) begin
					res.status = ST_FULL;
				end else if (op == OP_PUSH_FRONT) begin
					front_slot = (front_slot + DEPTH - 1) % DEPTH;
					deque_slots[front_slot] = value;
					held_count++;
				end else begin
					deque_slots[(front_slot + held_count) % DEPTH] = value;
					held_count++;
				end
			end
			default: begin
				if (held_count == 0) begin
					res.status = ST_EMPTY;
				end else if (op == OP_POP_FRONT) begin
					res.value  = deque_slots[front_slot];
					front_slot = (front_slot + 1) % DEPTH;
					held_count--;
				end else begin
					slot      = (front_slot + held_count - 1) % DEPTH;
					res.value = deque_slots[slot];
					held_count--;
				end
			end
		endcase
		res.occupancy = held_count[OCC_W-1:0];
		return res;
	endfunction

	// Offers one request beat after a random gap and records its prediction.
	task automatic send_request(op_t op, logic [VALUE_W-1:0] value, int unsigned max_gap,
			logic typed, deque_result_t want);
		int unsigned   gap;
		deque_result_t predicted;
		gap = $urandom_range(0, max_gap);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= op;
		s_tdata  <= value;
		do @(posedge clk); while (!s_tready);
		predicted = apply_deque_op(op, value);
		pending_results.push_back(typed ? want : predicted);
	endtask

	task automatic compare_field(string name, logic [VALUE_W-1:0] want, logic [VALUE_W-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			error_count++;
		end
	endtask

	// result side: random stalls, every beat checked against the oldest prediction
	initial begin
		int unsigned   stall;
		int unsigned   stall_max;
		deque_result_t want;
		stall_max = 5;
		wait (arst_n);
		forever begin
			if ($urandom_range(0, 15) == 0) stall_max = (stall_max == 0) ? 5 : 0;
			stall = $urandom_range(0, stall_max);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (!m_tvalid);
			if (pending_results.size() == 0) begin
				$error("result beat with no request outstanding");
				error_count++;
			end else begin
				want = pending_results.pop_front();
				compare_field("value_out", want.value, m_tdata[VALUE_W-1:0]);
				compare_field("status", VALUE_W'(want.status), VALUE_W'(m_tuser));
				compare_field("occupancy", VALUE_W'(want.occupancy),
					VALUE_W'(m_tdata[VALUE_W +: OCC_W]));
				compare_field("pad", '0, VALUE_W'(m_tdata[M_W-1:VALUE_W+OCC_W]));
			end
		end
	end

	initial begin
		int unsigned        sent;
		int unsigned        burst_len;
		int unsigned        push_pct;
		int unsigned        gap_max;
		op_t                op;
		logic [VALUE_W-1:0] value;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i]) begin
			send_request(directed_rows[i].op, directed_rows[i].value, 5,
				directed_rows[i].typed, directed_rows[i].want);
		end

		sent = 0;
		while (sent < RAND_N) begin
			// bursts lean toward filling, draining or neither
			case ($urandom_range(0, 2))
				0:       push_pct = 85;
				1:       push_pct = 15;
				default: push_pct = 50;
			endcase
			gap_max   = ($urandom_range(0, 3) == 0) ? 0 : 5;
			burst_len = $urandom_range(4, 40);
			repeat (burst_len) begin
				if ($urandom_range(0, 99) < push_pct)
					op = $urandom_range(0, 1) ? OP_PUSH_FRONT : OP_PUSH_BACK;
				else
					op = $urandom_range(0, 1) ? OP_POP_FRONT : OP_POP_BACK;
				case ($urandom_range(0, 15))
					0:       value = 32'h8000_0000;
					1:       value = 32'h7FFF_FFFF;
					2:       value = 32'hFFFF_FFFF;
					3:       value = 32'h0000_0000;
					default: value = $urandom;
				endcase
				send_request(op, value, gap_max, 1'b0, '0);
				sent++;
			end
		end
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (error_count == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule

[filelist.f]
rtl/deq_pkg.sv
rtl/double_ended_queue.sv
tb/sv/testbench.sv
